### hdl/wfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfc_pkg
// Shared codes, types and character helpers of the word frequency counter.
// ----------------------------------------------------------------------------
package wfc_pkg;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_TEXT  = 2'd1;
	localparam logic [1:0] ACT_END   = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	localparam logic [1:0] KIND_WORD = 2'd0;
	localparam logic [1:0] KIND_SUM  = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	localparam int          CNT_W     = 16;
	localparam logic [15:0] COUNT_MAX = 16'hFFFF;
	localparam logic [7:0]  APOS      = 8'h27;

	// broadcast controls to every cell of the slot row
	typedef struct packed {
		logic load;  // capture candidate bit from length match
		logic drop;  // clear candidate bit of the selected cell
		logic inc;   // bump count of the selected cell
		logic wr;    // allocate the target cell
	} cell_ctl_t;

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
		       (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == COUNT_MAX) ? v : v + 16'd1;
	endfunction

endpackage

### hdl/word_frequency_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_frequency_counter
// Streams text bytes into words and counts them in a row of slot cells.
// ----------------------------------------------------------------------------
// channel  dir  tuser          tdata                                      tlast
// s_*      in   action         text_byte, read_slot, read_position        -
// m_*      out  result_kind    status, slot, is_new, occurrences,         last
//                              distinct_words, read_byte, word_length
//
// A text byte that opens or extends a word is taken in S_IDLE, plus S_APP2
// after a held apostrophe. A finished word costs the slot search: S_FIND
// per candidate slot plus S_ISSUE and S_CHECK per compared character, then
// S_CPRD and S_CPWR per character to copy a new word into the text RAM.
// No clearing pass after reset: the used count gates every slot.
// A request is taken only when the result register is empty.
// ----------------------------------------------------------------------------
module word_frequency_counter #(
	parameter int TABLE_ENTRIES = 32,
	parameter int WORD_CHARS    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // text_byte, read_slot, read_position
	input  logic [1:0]  s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // status, slot, is_new, occurrences,
	                              // distinct_words, read_byte, word_length
	output logic [1:0]  m_tuser,  // result_kind
	output logic        m_tlast
);

	localparam int TE  = TABLE_ENTRIES;
	localparam int WC  = WORD_CHARS;
	localparam int SLW = (TE > 1) ? $clog2(TE) : 1;
	localparam int CW  = $clog2(WC);
	localparam int LW  = $clog2(WC + 1);
	localparam int UW  = $clog2(TE + 1);
	localparam int AW  = $clog2(TE * WC);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_APP2   = 4'd1;
	localparam logic [3:0] S_FIND   = 4'd2;
	localparam logic [3:0] S_ISSUE  = 4'd3;
	localparam logic [3:0] S_CHECK  = 4'd4;
	localparam logic [3:0] S_CPRD   = 4'd5;
	localparam logic [3:0] S_CPWR   = 4'd6;
	localparam logic [3:0] S_RDWAIT = 4'd7;
	localparam logic [3:0] S_SUM    = 4'd8;

	logic [3:0]    state_q;
	logic [LW-1:0] open_q;
	logic          pend_q;
	logic          lapos_q;
	logic [UW-1:0] used_q;
	logic          ovf_q;
	logic          end_q;
	logic [LW-1:0] len_q;
	logic [CW-1:0] idx_q;
	logic [7:0]    byte_q;
	logic          rok_q;
	logic          bok_q;
	logic [4:0]    rslot_q;
	logic [LW-1:0] rlen_q;
	logic [15:0]   rcnt_q;

	logic          o_valid_q;
	logic [1:0]    o_kind_q;
	logic          o_status_q;
	logic [4:0]    o_slot_q;
	logic          o_new_q;
	logic [15:0]   o_cnt_q;
	logic [5:0]    o_uniq_q;
	logic [7:0]    o_byte_q;
	logic [5:0]    o_len_q;
	logic          o_last_q;

	logic [1:0] act;
	logic [7:0] c_in;
	logic [4:0] rslot;
	logic [4:0] rpos;
	assign act   = s_tuser;
	assign c_in  = s_tdata[7:0];
	assign rslot = s_tdata[12:8];
	assign rpos  = s_tdata[17:13];

	logic acc;
	assign s_tready = (state_q == S_IDLE) && !o_valid_q;
	assign acc      = s_tvalid && s_tready;

	// slot row
	wfc_pkg::cell_ctl_t        ctl;
	logic [LW-1:0]             probe_len;
	logic [TE:0]               taken;
	logic [TE-1:0]             cell_sel;
	logic [LW-1:0]             cell_len [TE];
	logic [wfc_pkg::CNT_W-1:0] cell_cnt [TE];

	assign taken[0] = 1'b0;

	for (genvar i = 0; i < TE; i++) begin : g_cell
		wfc_cell #(.LW(LW)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.in_use    (UW'(i) < used_q),
			.target    (UW'(i) == used_q),
			.probe_len (probe_len),
			.taken_in  (taken[i]),
			.taken_out (taken[i+1]),
			.sel       (cell_sel[i]),
			.len       (cell_len[i]),
			.cnt       (cell_cnt[i])
		);
	end

	logic [SLW-1:0] sel_idx;
	always_comb begin
		sel_idx = '0;
		for (int i = 0; i < TE; i++) begin
			if (cell_sel[i]) begin
				sel_idx = sel_idx | SLW'(i);
			end
		end
	end

	// RAMs
	logic          w_we;
	logic [CW-1:0] w_waddr;
	logic [7:0]    w_wdata;
	logic [CW-1:0] w_raddr;
	logic [7:0]    w_rdata;
	logic          t_we;
	logic [AW-1:0] t_waddr;
	logic [AW-1:0] t_raddr;
	logic [7:0]    t_rdata;

	wfc_ram #(.W(8), .D(WC)) u_word_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	wfc_ram #(.W(8), .D(TE * WC)) u_text_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (w_rdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	logic          c_alnum;
	logic [LW-1:0] fin_len;
	logic          open_room;
	logic          finish;
	logic          rd_ok;
	logic [SLW-1:0] rd_idx;
	logic          last_char;
	logic          full;

	assign c_alnum   = wfc_pkg::is_alnum(c_in);
	assign fin_len   = lapos_q ? open_q - LW'(1) : open_q;
	assign open_room = open_q < LW'(WC);
	assign rd_idx    = SLW'(rslot);
	assign rd_ok     = (32'(rslot) < 32'(used_q)) && (32'(rslot) < TE);
	assign last_char = (LW'(idx_q) + LW'(1)) == len_q;
	assign full      = used_q == UW'(TE);

	// a request that closes the open word
	always_comb begin
		finish = 1'b0;
		if (acc && act == wfc_pkg::ACT_TEXT && !ovf_q) begin
			if (pend_q) begin
				finish = !c_alnum;
			end else begin
				finish = !c_alnum && !(c_in == wfc_pkg::APOS && open_q != '0) &&
				         open_q != '0;
			end
		end else if (acc && act == wfc_pkg::ACT_END) begin
			finish = !ovf_q && open_q != '0;
		end
	end

	always_comb begin
		ctl       = '0;
		probe_len = (state_q == S_IDLE) ? fin_len : len_q;
		w_we      = 1'b0;
		w_waddr   = CW'(open_q);
		w_wdata   = wfc_pkg::to_lower(c_in);
		w_raddr   = idx_q;
		t_we      = 1'b0;
		t_waddr   = AW'(used_q) * AW'(WC) + AW'(idx_q);
		t_raddr   = AW'(sel_idx) * AW'(WC) + AW'(idx_q);
		unique case (state_q)
			S_IDLE: begin
				ctl.load = finish;
				t_raddr  = AW'(rd_idx) * AW'(WC) + AW'(rpos);
				if (acc && act == wfc_pkg::ACT_TEXT && !ovf_q && open_room) begin
					if (pend_q && c_alnum) begin
						w_we    = 1'b1;
						w_wdata = wfc_pkg::APOS;
					end else if (!pend_q && c_alnum) begin
						w_we = 1'b1;
					end
				end
			end
			S_APP2: begin
				w_we    = open_room;
				w_wdata = wfc_pkg::to_lower(byte_q);
			end
			S_FIND: begin
				ctl.inc = taken[TE] && len_q == '0;
				ctl.wr  = !taken[TE] && !full && len_q == '0;
			end
			S_ISSUE: begin
			end
			S_CHECK: begin
				ctl.drop = w_rdata != t_rdata;
				ctl.inc  = (w_rdata == t_rdata) && last_char;
			end
			S_CPRD: begin
			end
			S_CPWR: begin
				t_we   = 1'b1;
				ctl.wr = last_char;
			end
			S_RDWAIT: begin
			end
			S_SUM: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			open_q    <= '0;
			pend_q    <= 1'b0;
			lapos_q   <= 1'b0;
			used_q    <= '0;
			ovf_q     <= 1'b0;
			end_q     <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			// the summary state reloads the register itself
			if (o_valid_q && m_tready && state_q != S_SUM) begin
				o_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						unique case (act)
							wfc_pkg::ACT_CLEAR: begin
								used_q  <= '0;
								ovf_q   <= 1'b0;
								open_q  <= '0;
								pend_q  <= 1'b0;
								lapos_q <= 1'b0;
							end
							wfc_pkg::ACT_TEXT: begin
								if (finish) begin
									open_q  <= '0;
									pend_q  <= 1'b0;
									lapos_q <= 1'b0;
									end_q   <= 1'b0;
									state_q <= S_FIND;
								end else if (!ovf_q) begin
									if (pend_q && c_alnum) begin
										// apostrophe now, the byte next cycle
										pend_q  <= 1'b0;
										if (open_room) begin
											open_q  <= open_q + LW'(1);
											lapos_q <= 1'b1;
										end
										state_q <= S_APP2;
									end else if (c_alnum) begin
										if (open_room) begin
											open_q  <= open_q + LW'(1);
											lapos_q <= 1'b0;
										end
									end else if (c_in == wfc_pkg::APOS && open_q != '0) begin
										pend_q <= 1'b1;
									end
								end
							end
							wfc_pkg::ACT_END: begin
								open_q  <= '0;
								pend_q  <= 1'b0;
								lapos_q <= 1'b0;
								if (finish) begin
									end_q   <= 1'b1;
									state_q <= S_FIND;
								end else begin
									state_q <= S_SUM;
								end
							end
							wfc_pkg::ACT_READ: begin
								rok_q   <= rd_ok;
								rslot_q <= rslot;
								rlen_q  <= cell_len[rd_idx];
								rcnt_q  <= cell_cnt[rd_idx];
								bok_q   <= rd_ok && (32'(rpos) < 32'(cell_len[rd_idx])) &&
								           (32'(rpos) < WC);
								state_q <= S_RDWAIT;
							end
							default: begin
							end
						endcase
					end
					len_q  <= fin_len;
					byte_q <= c_in;
					idx_q  <= '0;
				end
				S_APP2: begin
					if (open_room) begin
						open_q  <= open_q + LW'(1);
						lapos_q <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				S_FIND: begin
					idx_q <= '0;
					o_kind_q <= wfc_pkg::KIND_WORD;
					o_byte_q <= '0;
					o_len_q  <= 6'(len_q);
					o_last_q <= !end_q;
					if (taken[TE]) begin
						if (len_q == '0) begin
							o_valid_q  <= 1'b1;
							o_status_q <= ovf_q;
							o_slot_q   <= 5'(sel_idx);
							o_new_q    <= 1'b0;
							o_cnt_q    <= wfc_pkg::sat_inc(cell_cnt[sel_idx]);
							o_uniq_q   <= 6'(used_q);
							state_q    <= end_q ? S_SUM : S_IDLE;
						end else begin
							state_q <= S_ISSUE;
						end
					end else if (full) begin
						ovf_q      <= 1'b1;
						o_valid_q  <= 1'b1;
						o_status_q <= 1'b1;
						o_slot_q   <= '0;
						o_new_q    <= 1'b0;
						o_cnt_q    <= '0;
						o_uniq_q   <= 6'(used_q);
						state_q    <= end_q ? S_SUM : S_IDLE;
					end else if (len_q == '0) begin
						used_q     <= used_q + UW'(1);
						o_valid_q  <= 1'b1;
						o_status_q <= ovf_q;
						o_slot_q   <= 5'(used_q);
						o_new_q    <= 1'b1;
						o_cnt_q    <= 16'd1;
						o_uniq_q   <= 6'(used_q + UW'(1));
						state_q    <= end_q ? S_SUM : S_IDLE;
					end else begin
						state_q <= S_CPRD;
					end
				end
				S_ISSUE: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (w_rdata != t_rdata) begin
						// drop this slot, try the next candidate
						idx_q   <= '0;
						state_q <= S_FIND;
					end else if (last_char) begin
						o_valid_q  <= 1'b1;
						o_status_q <= ovf_q;
						o_slot_q   <= 5'(sel_idx);
						o_new_q    <= 1'b0;
						o_cnt_q    <= wfc_pkg::sat_inc(cell_cnt[sel_idx]);
						o_uniq_q   <= 6'(used_q);
						state_q    <= end_q ? S_SUM : S_IDLE;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_ISSUE;
					end
				end
				S_CPRD: begin
					state_q <= S_CPWR;
				end
				S_CPWR: begin
					if (last_char) begin
						used_q     <= used_q + UW'(1);
						o_valid_q  <= 1'b1;
						o_status_q <= ovf_q;
						o_slot_q   <= 5'(used_q);
						o_new_q    <= 1'b1;
						o_cnt_q    <= 16'd1;
						o_uniq_q   <= 6'(used_q + UW'(1));
						state_q    <= end_q ? S_SUM : S_IDLE;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_CPRD;
					end
				end
				S_RDWAIT: begin
					o_valid_q  <= 1'b1;
					o_kind_q   <= wfc_pkg::KIND_READ;
					o_status_q <= ovf_q;
					o_slot_q   <= rslot_q;
					o_new_q    <= 1'b0;
					o_cnt_q    <= rok_q ? rcnt_q : 16'd0;
					o_uniq_q   <= 6'(used_q);
					o_byte_q   <= bok_q ? t_rdata : 8'd0;
					o_len_q    <= rok_q ? 6'(rlen_q) : 6'd0;
					o_last_q   <= 1'b1;
					state_q    <= S_IDLE;
				end
				S_SUM: begin
					// hold until the word result has gone
					if (!o_valid_q || m_tready) begin
						o_valid_q  <= 1'b1;
						o_kind_q   <= wfc_pkg::KIND_SUM;
						o_status_q <= ovf_q;
						o_slot_q   <= '0;
						o_new_q    <= 1'b0;
						o_cnt_q    <= '0;
						o_uniq_q   <= 6'(used_q);
						o_byte_q   <= '0;
						o_len_q    <= '0;
						o_last_q   <= 1'b1;
						end_q      <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tuser  = o_kind_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {5'd0, o_len_q, o_byte_q, o_uniq_q, o_cnt_q, o_new_q, o_slot_q,
	                   o_status_q};

endmodule

### hdl/wfc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module wfc_ram #(
	parameter int W = 8,
	parameter int D = 32
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/wfc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfc_cell
// One slot of the table: length, count and candidate bit, with a priority
// link that passes "a lower slot is already chosen" to the next cell.
// ----------------------------------------------------------------------------
module wfc_cell #(
	parameter int LW = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  wfc_pkg::cell_ctl_t      ctl,
	input  logic                    in_use,
	input  logic                    target,
	input  logic [LW-1:0]           probe_len,
	input  logic                    taken_in,
	output logic                    taken_out,
	output logic                    sel,
	output logic [LW-1:0]           len,
	output logic [wfc_pkg::CNT_W-1:0] cnt
);

	logic                      cand_q;
	logic [LW-1:0]             len_q;
	logic [wfc_pkg::CNT_W-1:0] cnt_q;

	assign sel       = cand_q & ~taken_in;
	assign taken_out = taken_in | cand_q;
	assign len       = len_q;
	assign cnt       = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= 1'b0;
		end else if (ctl.load) begin
			cand_q <= in_use && (len_q == probe_len);
		end else if (ctl.drop && sel) begin
			cand_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr && target) begin
			len_q <= probe_len;
			cnt_q <= wfc_pkg::CNT_W'(1);
		end else if (ctl.inc && sel) begin
			cnt_q <= wfc_pkg::sat_inc(cnt_q);
		end
	end

endmodule

### hdl/wfc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfc_checker
// Port-level checks of the word frequency counter, bound to the top level.
// ----------------------------------------------------------------------------
module wfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("stalled result changed");

	a_sum_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == wfc_pkg::KIND_SUM |-> m_tlast)
		else $error("summary not marked last");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == wfc_pkg::ACT_CLEAR |=> !m_tvalid)
		else $error("clear produced a result");

	a_new_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == wfc_pkg::KIND_WORD && m_tdata[6] |->
		m_tdata[22:7] == 16'd1 && !m_tdata[0])
		else $error("new word with bad count or status");

endmodule

bind word_frequency_counter wfc_checker u_wfc_checker (.*);
